### hw/rtl/dsds_pkg.sv
// Shared types, codes and constants of the dual stepper drive sequencer.
`timescale 1ns / 1ps

package dsds_pkg;

	// actions (tuser)
	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_DRIVE = 2'd1;
	localparam logic [1:0] ACT_DIST  = 2'd2;
	localparam logic [1:0] ACT_TURN  = 2'd3;

	localparam logic [1:0] DRV_STOP = 2'd0;
	localparam logic [1:0] DRV_FWD  = 2'd1;
	localparam logic [1:0] DRV_BWD  = 2'd2;

	localparam logic [1:0] TURN_STRAIGHT = 2'd0;
	localparam logic [1:0] TURN_LEFT     = 2'd1;
	localparam logic [1:0] TURN_RIGHT    = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_STEP_MODE  = 3'd0;
	localparam logic [2:0] REG_STEPS_ROT  = 3'd1;
	localparam logic [2:0] REG_WHEEL_CIRC = 3'd2;
	localparam logic [2:0] REG_TURN_CIRC  = 3'd3;
	localparam logic [2:0] REG_LEFT_REV   = 3'd4;
	localparam logic [2:0] REG_RIGHT_REV  = 3'd5;

	localparam int NUM_W     = 44;	// turn numerator: 13 + 15 + 16 bits
	localparam int DRV_NUM_W = 35;	// drive numerator: 19 + 16 bits
	localparam int DEN_W     = 21;	// 360 * 4095 fits
	localparam int MUL_A_W   = 28;
	localparam int MUL_B_W   = 16;
	localparam int SPR_W     = 16;
	localparam int ITER_W    = 6;

	localparam logic [ITER_W-1:0] ITER_Q    = ITER_W'(SPR_W);
	localparam logic [ITER_W-1:0] ITER_DRV  = ITER_W'(DRV_NUM_W);
	localparam logic [ITER_W-1:0] ITER_TURN = ITER_W'(NUM_W);
	localparam int DRV_PRESHIFT = NUM_W - DRV_NUM_W;

	localparam logic [MUL_B_W-1:0] DEG_FULL   = 16'd360;
	localparam logic [MUL_B_W-1:0] CM_TO_MM   = 16'd10;
	localparam logic [MUL_B_W-1:0] UNIT_SCALE = 16'd1;
	localparam logic signed [5:0] PHASE_MAX = 6'sd7;
	localparam logic [15:0] STEPS_MAX = 16'hFFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_DEN,
		ST_MUL_NUM,
		ST_DIV_Q,
		ST_MUL_Q,
		ST_DIV_LD,
		ST_DIV_B,
		ST_APPLY_WRITE_PREP
	} seq_state_t;

	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  num;
		logic [DEN_W-1:0]  den;
		logic [ITER_W-1:0] iters;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [NUM_W-1:0] quo;
	} div_rsp_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [1:0] drive;
		logic [1:0] turn;
	} step_ctl_t;

	function automatic logic [3:0] coil_of(input logic [2:0] ph);
		logic [3:0] c;
		unique case (ph)
			3'd0: c = 4'd8;
			3'd1: c = 4'd12;
			3'd2: c = 4'd4;
			3'd3: c = 4'd6;
			3'd4: c = 4'd2;
			3'd5: c = 4'd3;
			3'd6: c = 4'd1;
			default: c = 4'd9;
		endcase
		return c;
	endfunction

endpackage

### hw/rtl/dsds_divider.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module dsds_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  dsds_pkg::div_req_t req,
	output dsds_pkg::div_rsp_t rsp
);

	localparam int NW = dsds_pkg::NUM_W;
	localparam int DW = dsds_pkg::DEN_W;

	logic [NW-1:0]                 num_q;
	logic [DW-1:0]                 rem_q;
	logic [DW-1:0]                 den_q;
	logic [dsds_pkg::ITER_W-1:0]   cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [DW:0]                   trial;
	logic [DW:0]                   diff;
	logic                          ge;

	assign trial = {rem_q, num_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == dsds_pkg::ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// numerator shifts out at the top, quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], ge};
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = num_q;

endmodule

### hw/rtl/dsds_phase_step.sv
// Phase advance with wrap and coil lookup for one motor.
`timescale 1ns / 1ps

module dsds_phase_step (
	input  dsds_pkg::step_ctl_t ctl,
	input  logic [2:0]          phase,
	input  logic                drive_neg,
	input  logic                turn_neg,
	output logic [2:0]          phase_next,
	output logic [3:0]          coils
);

	logic signed [5:0] m;
	logic signed [5:0] p;

	always_comb begin
		m = $signed({4'b0, ctl.mode});
		p = $signed({3'b0, phase});
		unique case (ctl.drive)
			dsds_pkg::DRV_FWD: p = drive_neg ? p - m : p + m;
			dsds_pkg::DRV_BWD: p = drive_neg ? p + m : p - m;
			default: ;
		endcase
		unique case (ctl.turn)
			dsds_pkg::TURN_LEFT:  p = turn_neg ? p + m : p - m;
			dsds_pkg::TURN_RIGHT: p = turn_neg ? p - m : p + m;
			default: ;
		endcase
		// overflow restarts at mode-1; mode 0 then falls to the underflow rule
		if (p > dsds_pkg::PHASE_MAX)
			p = m - 6'sd1;
		if (p < 6'sd0)
			p = dsds_pkg::PHASE_MAX;
		phase_next = p[2:0];
		coils = dsds_pkg::coil_of(phase_next);
	end

endmodule

### hw/rtl/dual_stepper_drive_sequencer.sv
// Top level: command sequencer, shared multiplier and divider, motor state.
`timescale 1ns / 1ps

// Dual stepper drive sequencer.
// Input beats (s_*) carry a command: tuser is the action (tick, drive
// unlimited, drive for a distance, turn), tdata the directions and amount.
// Each accepted beat gives exactly one output beat (m_*) with both coil
// patterns, the moving flag and the remaining step count after that item.
// Ticks, unlimited drive commands and commands with a zero step mode or
// wheel circumference go straight to the write state; it updates the
// motor state, then loads the output once the output register is free.
// Distance and turn commands compute the step budget with one multiplier
// (three products in turn) and a radix-2 divider: first the steps per
// increment, then the budget, which is passed on to the write state.
// One item is in work at a time; s_tready is high only while the sequencer
// is idle.
// The result sits in an output register, so the next item is taken while
// it waits; a stalled receiver holds only the following result.
// Reset loads the default configuration, zeroes both phases, the coils
// and the budget, and stops the drive. Write configuration only when idle.

module dual_stepper_drive_sequencer #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,	// drive_dir[1:0], turn_dir[3:2], amount[18:4], zeros
	input  logic [1:0]  s_tuser,	// action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata	// coils_left[3:0], coils_right[7:4], moving[8],
	                            // steps_remaining[24:9], zeros
);

	localparam int NW = dsds_pkg::NUM_W;
	localparam int AW = dsds_pkg::MUL_A_W;
	localparam int BW = dsds_pkg::MUL_B_W;

	// configuration
	logic [1:0]  mode_q;
	logic [15:0] spr_q;
	logic [11:0] wheel_q;
	logic [12:0] tcirc_q;
	logic        lrev_q;
	logic        rrev_q;

	// current item
	logic [1:0]  act_q;
	logic [1:0]  ddir_q;
	logic [1:0]  tdir_q;
	logic [14:0] amount_q;

	// motor state
	logic [2:0]             phl_q;
	logic [2:0]             phr_q;
	logic [7:0]             coil_q;
	logic [COUNT_WIDTH-1:0] budget_q;
	logic [1:0]             drive_q;
	logic [1:0]             turn_q;

	// arithmetic
	logic [dsds_pkg::DEN_W-1:0] den_q;
	logic [AW-1:0]              numr_q;
	logic [15:0]                q_q;
	logic [NW-1:0]              prod_q;
	logic [COUNT_WIDTH-1:0]     result_q;
	logic [AW-1:0]              mul_a;
	logic [BW-1:0]              mul_b;
	logic [NW-1:0]              mul_p;

	dsds_pkg::seq_state_t state_q, state_d;
	dsds_pkg::div_req_t   div_req;
	dsds_pkg::div_rsp_t   div_rsp;
	dsds_pkg::step_ctl_t  step_ctl;

	logic       accept;
	logic       is_turn;
	logic       zero_div;
	logic       out_free;
	logic [1:0] in_ddir;
	logic [1:0] in_tdir;
	logic [2:0] phl_n;
	logic [2:0] phr_n;
	logic [3:0] coils_l;
	logic [3:0] coils_r;
	logic [NW-1:0] budget_x;
	logic [15:0]   steps_out;

	localparam dsds_pkg::seq_state_t ST_WRITE = dsds_pkg::ST_APPLY_WRITE_PREP;

	// extra state for the apply cycle kept as a flag to share the write state
	logic apply_q;

	assign accept   = s_tvalid && s_tready;
	assign is_turn  = act_q == dsds_pkg::ACT_TURN;
	assign zero_div = (mode_q == 2'd0) || (wheel_q == 12'd0);
	assign out_free = !m_tvalid || m_tready;
	assign in_ddir  = (s_tdata[1:0] == 2'd3) ? dsds_pkg::DRV_STOP : s_tdata[1:0];
	assign in_tdir  = (s_tdata[3:2] == 2'd3) ? dsds_pkg::TURN_STRAIGHT : s_tdata[3:2];

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 2'd1;
			spr_q   <= 16'd4096;
			wheel_q <= 12'd204;
			tcirc_q <= 13'd565;
			lrev_q  <= 1'b0;
			rrev_q  <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dsds_pkg::REG_STEP_MODE:  mode_q  <= cfg_data[1:0];
				dsds_pkg::REG_STEPS_ROT:  spr_q   <= cfg_data;
				dsds_pkg::REG_WHEEL_CIRC: wheel_q <= cfg_data[11:0];
				dsds_pkg::REG_TURN_CIRC:  tcirc_q <= cfg_data[12:0];
				dsds_pkg::REG_LEFT_REV:   lrev_q  <= cfg_data[0];
				dsds_pkg::REG_RIGHT_REV:  rrev_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dsds_pkg::ST_IDLE: begin
				if (accept) begin
					if ((s_tuser == dsds_pkg::ACT_DIST || s_tuser == dsds_pkg::ACT_TURN)
					    && !zero_div)
						state_d = dsds_pkg::ST_MUL_DEN;
					else
						state_d = ST_WRITE;
				end
			end
			dsds_pkg::ST_MUL_DEN: state_d = dsds_pkg::ST_MUL_NUM;
			dsds_pkg::ST_MUL_NUM: state_d = dsds_pkg::ST_DIV_Q;
			dsds_pkg::ST_DIV_Q:   if (div_rsp.done) state_d = dsds_pkg::ST_MUL_Q;
			dsds_pkg::ST_MUL_Q:   state_d = dsds_pkg::ST_DIV_LD;
			dsds_pkg::ST_DIV_LD:  state_d = dsds_pkg::ST_DIV_B;
			dsds_pkg::ST_DIV_B:   if (div_rsp.done) state_d = ST_WRITE;
			default:              if (!apply_q && out_free) state_d = dsds_pkg::ST_IDLE;
		endcase
	end

	// datapath controls
	always_comb begin
		s_tready      = state_q == dsds_pkg::ST_IDLE;
		mul_a         = '0;
		mul_b         = '0;
		div_req.start = 1'b0;
		div_req.num   = '0;
		div_req.den   = '0;
		div_req.iters = '0;
		unique case (state_q)
			dsds_pkg::ST_MUL_DEN: begin
				mul_a         = AW'(wheel_q);
				mul_b         = is_turn ? dsds_pkg::DEG_FULL : dsds_pkg::UNIT_SCALE;
				// steps per increment: spr / mode, numerator left-aligned
				div_req.start = 1'b1;
				div_req.num   = {spr_q, (NW - dsds_pkg::SPR_W)'(0)};
				div_req.den   = dsds_pkg::DEN_W'(mode_q);
				div_req.iters = dsds_pkg::ITER_Q;
			end
			dsds_pkg::ST_MUL_NUM: begin
				mul_a = is_turn ? AW'(tcirc_q) : AW'(amount_q);
				mul_b = is_turn ? BW'(amount_q) : dsds_pkg::CM_TO_MM;
			end
			dsds_pkg::ST_MUL_Q: begin
				mul_a = numr_q;
				mul_b = q_q;
			end
			dsds_pkg::ST_DIV_LD: begin
				div_req.start = 1'b1;
				div_req.num   = is_turn ? prod_q : (prod_q << dsds_pkg::DRV_PRESHIFT);
				div_req.den   = den_q;
				div_req.iters = is_turn ? dsds_pkg::ITER_TURN : dsds_pkg::ITER_DRV;
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	dsds_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign step_ctl.mode  = mode_q;
	assign step_ctl.drive = drive_q;
	assign step_ctl.turn  = turn_q;

	dsds_phase_step u_step_l (
		.ctl        (step_ctl),
		.phase      (phl_q),
		.drive_neg  (lrev_q),
		.turn_neg   (lrev_q),
		.phase_next (phl_n),
		.coils      (coils_l)
	);

	// right motor turns opposite to its drive sign
	dsds_phase_step u_step_r (
		.ctl        (step_ctl),
		.phase      (phr_q),
		.drive_neg  (rrev_q),
		.turn_neg   (!rrev_q),
		.phase_next (phr_n),
		.coils      (coils_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dsds_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// apply_q marks the first cycle in the write state, where the item updates the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			apply_q <= 1'b0;
		end else begin
			apply_q <= (state_d == ST_WRITE) && (state_q != ST_WRITE);
		end
	end

	// item latch and arithmetic registers
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q    <= s_tuser;
			ddir_q   <= in_ddir;
			tdir_q   <= in_tdir;
			amount_q <= s_tdata[18:4];
			result_q <= '0;
		end
		if (state_q == dsds_pkg::ST_MUL_DEN)
			den_q <= mul_p[dsds_pkg::DEN_W-1:0];
		if (state_q == dsds_pkg::ST_MUL_NUM)
			numr_q <= mul_p[AW-1:0];
		if (state_q == dsds_pkg::ST_DIV_Q && div_rsp.done)
			q_q <= div_rsp.quo[15:0];
		if (state_q == dsds_pkg::ST_MUL_Q)
			prod_q <= mul_p;
		if (state_q == dsds_pkg::ST_DIV_B && div_rsp.done) begin
			if ((div_rsp.quo >> COUNT_WIDTH) != '0)
				result_q <= '1;
			else
				result_q <= div_rsp.quo[COUNT_WIDTH-1:0];
		end
	end

	// motor state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phl_q    <= '0;
			phr_q    <= '0;
			coil_q   <= '0;
			budget_q <= '0;
			drive_q  <= dsds_pkg::DRV_STOP;
			turn_q   <= dsds_pkg::TURN_STRAIGHT;
		end else if (state_q == ST_WRITE && apply_q) begin
			unique case (act_q)
				dsds_pkg::ACT_TICK: begin
					phl_q  <= phl_n;
					phr_q  <= phr_n;
					coil_q <= {coils_r, coils_l};
					if (budget_q != '0) begin
						budget_q <= budget_q - 1'b1;
						if (budget_q == COUNT_WIDTH'(1)) begin
							drive_q <= dsds_pkg::DRV_STOP;
							turn_q  <= dsds_pkg::TURN_STRAIGHT;
						end
					end
				end
				dsds_pkg::ACT_DRIVE: begin
					drive_q  <= ddir_q;
					budget_q <= '0;
				end
				dsds_pkg::ACT_DIST: begin
					drive_q  <= ddir_q;
					budget_q <= result_q;
				end
				default: begin
					drive_q  <= dsds_pkg::DRV_STOP;
					turn_q   <= tdir_q;
					budget_q <= result_q;
				end
			endcase
		end
	end

	assign budget_x  = NW'(budget_q);
	assign steps_out = (budget_x > NW'(dsds_pkg::STEPS_MAX)) ? dsds_pkg::STEPS_MAX
	                                                          : budget_x[15:0];

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (state_q == ST_WRITE && !apply_q && out_free) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE && !apply_q && out_free)
			m_tdata <= {7'b0, steps_out,
			            (drive_q != dsds_pkg::DRV_STOP) || (turn_q != dsds_pkg::TURN_STRAIGHT),
			            coil_q};
	end

	// divider is never left running once the sequencer is back at idle
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dsds_pkg::ST_IDLE |-> !div_rsp.busy)
		else $error("divider busy while sequencer idle");

	// a tick that spends the last step stops the drive and the turn
	a_count_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE && apply_q && act_q == dsds_pkg::ACT_TICK
		 && budget_q == COUNT_WIDTH'(1))
		|=> (budget_q == '0 && drive_q == dsds_pkg::DRV_STOP
		     && turn_q == dsds_pkg::TURN_STRAIGHT))
		else $error("countdown end did not stop the motors");

	// a new result only comes out of the write state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_WRITE && !$past(apply_q))
		else $error("result loaded outside the write state");

endmodule

### sim/testbench.sv
// Testbench of the dual stepper drive sequencer: directed table, random runs, self-checking.
`timescale 1ns / 1ps

module testbench;

	typedef struct packed {
		logic [3:0]  coils_l;
		logic [3:0]  coils_r;
		logic        moving;
		logic [15:0] steps;
	} drive_out_t;

	typedef struct {
		logic        is_write;
		logic [2:0]  reg_idx;
		logic [15:0] reg_val;
		logic [1:0]  act;
		logic [1:0]  ddir;
		logic [1:0]  tdir;
		logic [14:0] amt;
		logic        typed;
		drive_out_t  out;
	} plan_row_t;

	localparam logic [3:0] PHASE_COILS [8] = '{4'd8, 4'd12, 4'd4, 4'd6, 4'd2, 4'd3, 4'd1, 4'd9};
	localparam int RANDOM_ITEMS = 650;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b1;
	logic [31:0] m_tdata;

	// model of the motor state and its own copy of the registers
	logic [1:0]  mode_cfg;
	logic [15:0] spr_cfg;
	logic [11:0] wheel_cfg;
	logic [12:0] track_cfg;
	logic        lrev_cfg;
	logic        rrev_cfg;
	logic [2:0]  phase_l;
	logic [2:0]  phase_r;
	logic [7:0]  coil_word;
	logic [15:0] budget;
	logic [1:0]  drive_mode;
	logic [1:0]  turn_mode;

	drive_out_t  outputs_due[$];
	plan_row_t   plan[$];
	int          mismatches = 0;
	int          accepted = 0;
	int          burst_left = 0;

	dual_stepper_drive_sequencer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("dual_stepper_drive_sequencer test failed");
		$finish;
	end

	function automatic logic [15:0] steps_for(longint unsigned numer, longint unsigned den_k);
		longint unsigned q;
		longint unsigned r;
		if (mode_cfg == 2'd0 || wheel_cfg == 12'd0)
			return 16'd0;
		q = spr_cfg / mode_cfg;
		r = (numer * q) / (den_k * wheel_cfg);
		return (r > 64'd65535) ? 16'hFFFF : r[15:0];
	endfunction

	function automatic logic [2:0] next_phase(logic [2:0] ph, int sgn, int tsgn);
		int m;
		int p;
		m = mode_cfg;
		p = ph;
		if (drive_mode == dsds_pkg::DRV_FWD)
			p += m * sgn;
		else if (drive_mode == dsds_pkg::DRV_BWD)
			p -= m * sgn;
		if (turn_mode == dsds_pkg::TURN_LEFT)
			p -= m * tsgn;
		else if (turn_mode == dsds_pkg::TURN_RIGHT)
			p += m * tsgn;
		if (p > 7)
			p = m - 1;
		if (p < 0)
			p = 7;
		return p[2:0];
	endfunction

	function automatic drive_out_t motor_step(logic [1:0] act, logic [1:0] ddir, logic [1:0] tdir,
			logic [14:0] amt);
		drive_out_t o;
		int sl;
		int sr;
		if (ddir == 2'd3)
			ddir = dsds_pkg::DRV_STOP;
		if (tdir == 2'd3)
			tdir = dsds_pkg::TURN_STRAIGHT;
		sl = lrev_cfg ? -1 : 1;
		sr = rrev_cfg ? -1 : 1;
		case (act)
			dsds_pkg::ACT_TICK: begin
				phase_l = next_phase(phase_l, sl, sl);
				phase_r = next_phase(phase_r, sr, -sr);
				coil_word = {PHASE_COILS[phase_r], PHASE_COILS[phase_l]};
				if (budget != 0) begin
					budget--;
					if (budget == 0) begin
						drive_mode = dsds_pkg::DRV_STOP;
						turn_mode = dsds_pkg::TURN_STRAIGHT;
					end
				end
			end
			dsds_pkg::ACT_DRIVE: begin
				drive_mode = ddir;
				budget = '0;
			end
			dsds_pkg::ACT_DIST: begin
				budget = steps_for(longint'(amt) * 10, 1);
				drive_mode = ddir;
			end
			default: begin
				drive_mode = dsds_pkg::DRV_STOP;
				budget = steps_for(longint'(track_cfg) * amt, 360);
				turn_mode = tdir;
			end
		endcase
		o.coils_l = coil_word[3:0];
		o.coils_r = coil_word[7:4];
		o.moving = (drive_mode != dsds_pkg::DRV_STOP) || (turn_mode != dsds_pkg::TURN_STRAIGHT);
		o.steps = budget;
		return o;
	endfunction

	function automatic logic [14:0] rand_amount();
		case ($urandom_range(0, 3))
			0: return 15'($urandom_range(0, 10));
			1: return $urandom_range(0, 1) ? 15'h7FFF : 15'd0;
			default: return 15'($urandom_range(0, 32767));
		endcase
	endfunction

	function automatic plan_row_t item(logic [1:0] act, logic [1:0] ddir, logic [1:0] tdir,
			logic [14:0] amt);
		plan_row_t r;
		r = '{default: '0};
		r.act = act;
		r.ddir = ddir;
		r.tdir = tdir;
		r.amt = amt;
		return r;
	endfunction

	function automatic plan_row_t known(logic [1:0] act, logic [1:0] ddir, logic [1:0] tdir,
			logic [14:0] amt, drive_out_t out);
		plan_row_t r;
		r = item(act, ddir, tdir, amt);
		r.typed = 1'b1;
		r.out = out;
		return r;
	endfunction

	function automatic plan_row_t wr(logic [2:0] idx, logic [15:0] val);
		plan_row_t r;
		r = '{default: '0};
		r.is_write = 1'b1;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	// one beat in, with bursts and gaps; the model runs at the accepting edge
	task automatic send_item(logic [1:0] act, logic [1:0] ddir, logic [1:0] tdir, logic [14:0] amt,
			logic typed = 1'b0, drive_out_t typed_out = '0);
		drive_out_t o;
		if (burst_left == 0) begin
			repeat ($urandom_range(0, 3) == 0 ? $urandom_range(4, 90) : $urandom_range(1, 3))
				@(posedge clk);
			burst_left = $urandom_range(0, 4) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {5'd0, amt, tdir, ddir};
		do @(posedge clk); while (!s_tready);
		o = motor_step(act, ddir, tdir, amt);
		outputs_due.push_back(typed ? typed_out : o);
		accepted++;
		burst_left--;
		if (burst_left == 0)
			s_tvalid <= 1'b0;
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		if (burst_left != 0) begin
			s_tvalid <= 1'b0;
			burst_left = 0;
		end
		while (outputs_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			dsds_pkg::REG_STEP_MODE:  mode_cfg = val[1:0];
			dsds_pkg::REG_STEPS_ROT:  spr_cfg = val;
			dsds_pkg::REG_WHEEL_CIRC: wheel_cfg = val[11:0];
			dsds_pkg::REG_TURN_CIRC:  track_cfg = val[12:0];
			dsds_pkg::REG_LEFT_REV:   lrev_cfg = val[0];
			dsds_pkg::REG_RIGHT_REV:  rrev_cfg = val[0];
			default: ;
		endcase
	endtask

	task automatic shuffle_config();
		logic [15:0] v;
		case ($urandom_range(0, 9))
			0: v = 16'd0;
			1: v = 16'd3;
			2, 3, 4, 5: v = 16'd1;
			default: v = 16'd2;
		endcase
		write_reg(dsds_pkg::REG_STEP_MODE, v);
		case ($urandom_range(0, 4))
			0: v = $urandom_range(0, 1) ? 16'hFFFF : 16'd1;
			1, 2: v = 16'($urandom_range(1, 32));
			default: v = 16'($urandom_range(1, 65535));
		endcase
		write_reg(dsds_pkg::REG_STEPS_ROT, v);
		case ($urandom_range(0, 9))
			0: v = 16'd0;
			1, 2: v = 16'd1;
			3, 4, 5: v = 16'd4095;
			default: v = 16'($urandom_range(1, 4095));
		endcase
		write_reg(dsds_pkg::REG_WHEEL_CIRC, v);
		case ($urandom_range(0, 3))
			0: v = 16'd1;
			1: v = 16'd8191;
			default: v = 16'($urandom_range(1, 8191));
		endcase
		write_reg(dsds_pkg::REG_TURN_CIRC, v);
		write_reg(dsds_pkg::REG_LEFT_REV, 16'($urandom_range(0, 1)));
		write_reg(dsds_pkg::REG_RIGHT_REV, 16'($urandom_range(0, 1)));
	endtask

	task automatic report(string field, logic [31:0] want, logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, want, got);
	endtask

	// receiver: check each beat out, stall in changing styles
	int stall_style = 0;
	int style_left = 100;
	int rx_cycle = 0;

	always @(posedge clk) begin : result_check
		drive_out_t want;
		drive_out_t got;
		logic rdy;
		if (arst_n && m_tvalid && m_tready) begin
			got.coils_l = m_tdata[3:0];
			got.coils_r = m_tdata[7:4];
			got.moving = m_tdata[8];
			got.steps = m_tdata[24:9];
			if (outputs_due.size() == 0) begin
				report("unexpected beat", 32'd0, m_tdata);
			end else begin
				want = outputs_due.pop_front();
				if (got.coils_l !== want.coils_l)
					report("coils_left", want.coils_l, got.coils_l);
				if (got.coils_r !== want.coils_r)
					report("coils_right", want.coils_r, got.coils_r);
				if (got.moving !== want.moving)
					report("moving", want.moving, got.moving);
				if (got.steps !== want.steps)
					report("steps_remaining", want.steps, got.steps);
			end
		end
		rx_cycle++;
		style_left--;
		if (style_left == 0) begin
			stall_style = $urandom_range(0, 3);
			style_left = $urandom_range(20, 200);
		end
		case (stall_style)
			0: rdy = 1'b1;
			1: rdy = $urandom_range(0, 3) != 0;
			2: rdy = $urandom_range(0, 3) == 0;
			default: rdy = (rx_cycle % 7) >= 3;
		endcase
		m_tready <= rdy;
	end

	initial begin : stimulus
		plan_row_t r;
		logic [1:0] act;
		int n_ticks;
		int next_cfg;

		mode_cfg = 2'd1;
		spr_cfg = 16'd4096;
		wheel_cfg = 12'd204;
		track_cfg = 13'd565;
		lrev_cfg = 1'b0;
		rrev_cfg = 1'b1;
		phase_l = '0;
		phase_r = '0;
		coil_word = '0;
		budget = '0;
		drive_mode = dsds_pkg::DRV_STOP;
		turn_mode = dsds_pkg::TURN_STRAIGHT;

		// coils stay low until the first tick
		plan.push_back(known(dsds_pkg::ACT_DRIVE, dsds_pkg::DRV_FWD, dsds_pkg::TURN_STRAIGHT,
			15'd0, '{4'd0, 4'd0, 1'b1, 16'd0}));
		plan.push_back(known(dsds_pkg::ACT_TICK, dsds_pkg::DRV_STOP, dsds_pkg::TURN_STRAIGHT,
			15'd0, '{4'd12, 4'd9, 1'b1, 16'd0}));
		// unused direction codes on a tick are ignored
		plan.push_back(known(dsds_pkg::ACT_TICK, 2'd3, 2'd3, 15'h7FFF,
			'{4'd4, 4'd1, 1'b1, 16'd0}));
		plan.push_back(known(dsds_pkg::ACT_DIST, dsds_pkg::DRV_BWD, dsds_pkg::TURN_STRAIGHT,
			15'd0, '{4'd4, 4'd1, 1'b1, 16'd0}));
		plan.push_back(known(dsds_pkg::ACT_DIST, dsds_pkg::DRV_FWD, dsds_pkg::TURN_STRAIGHT,
			15'h7FFF, '{4'd4, 4'd1, 1'b1, 16'hFFFF}));
		plan.push_back(known(dsds_pkg::ACT_DIST, dsds_pkg::DRV_FWD, dsds_pkg::TURN_STRAIGHT,
			15'd1, '{4'd4, 4'd1, 1'b1, 16'd200}));
		plan.push_back(known(dsds_pkg::ACT_TURN, dsds_pkg::DRV_STOP, dsds_pkg::TURN_LEFT,
			15'd0, '{4'd4, 4'd1, 1'b1, 16'd0}));
		plan.push_back(item(dsds_pkg::ACT_TICK, dsds_pkg::DRV_FWD, dsds_pkg::TURN_RIGHT, 15'd5));
		plan.push_back(known(dsds_pkg::ACT_TURN, dsds_pkg::DRV_BWD, dsds_pkg::TURN_RIGHT,
			15'd1, '{4'd12, 4'd3, 1'b1, 16'd31}));
		plan.push_back(known(dsds_pkg::ACT_TURN, dsds_pkg::DRV_FWD, dsds_pkg::TURN_RIGHT,
			15'h7FFF, '{4'd12, 4'd3, 1'b1, 16'hFFFF}));
		// straight turn with a count: not moving, yet still counted down
		plan.push_back(known(dsds_pkg::ACT_TURN, dsds_pkg::DRV_STOP, 2'd3, 15'd2,
			'{4'd12, 4'd3, 1'b0, 16'd63}));
		plan.push_back(item(dsds_pkg::ACT_TICK, dsds_pkg::DRV_STOP, dsds_pkg::TURN_STRAIGHT,
			15'd0));
		plan.push_back(item(dsds_pkg::ACT_DIST, 2'd3, dsds_pkg::TURN_LEFT, 15'd1));
		// budget of one: the next tick ends the move
		plan.push_back(wr(dsds_pkg::REG_STEPS_ROT, 16'd8));
		plan.push_back(wr(dsds_pkg::REG_WHEEL_CIRC, 16'd4095));
		plan.push_back(item(dsds_pkg::ACT_DIST, dsds_pkg::DRV_FWD, dsds_pkg::TURN_STRAIGHT,
			15'd52));
		plan.push_back(item(dsds_pkg::ACT_TICK, dsds_pkg::DRV_STOP, dsds_pkg::TURN_STRAIGHT,
			15'd0));
		plan.push_back(item(dsds_pkg::ACT_DRIVE, dsds_pkg::DRV_STOP, dsds_pkg::TURN_LEFT, 15'd9));
		plan.push_back(wr(dsds_pkg::REG_WHEEL_CIRC, 16'd0));
		plan.push_back(item(dsds_pkg::ACT_DIST, dsds_pkg::DRV_FWD, dsds_pkg::TURN_STRAIGHT,
			15'h7FFF));
		// full step, reversed signs, widest settings
		plan.push_back(wr(dsds_pkg::REG_WHEEL_CIRC, 16'd4095));
		plan.push_back(wr(dsds_pkg::REG_STEP_MODE, 16'd2));
		plan.push_back(wr(dsds_pkg::REG_LEFT_REV, 16'd1));
		plan.push_back(wr(dsds_pkg::REG_RIGHT_REV, 16'd0));
		plan.push_back(wr(dsds_pkg::REG_TURN_CIRC, 16'd8191));
		plan.push_back(wr(dsds_pkg::REG_STEPS_ROT, 16'hFFFF));
		plan.push_back(item(dsds_pkg::ACT_DRIVE, dsds_pkg::DRV_BWD, dsds_pkg::TURN_STRAIGHT,
			15'd0));
		plan.push_back(item(dsds_pkg::ACT_TICK, dsds_pkg::DRV_STOP, dsds_pkg::TURN_STRAIGHT,
			15'd0));
		plan.push_back(item(dsds_pkg::ACT_TICK, dsds_pkg::DRV_STOP, dsds_pkg::TURN_STRAIGHT,
			15'd0));
		plan.push_back(item(dsds_pkg::ACT_TICK, dsds_pkg::DRV_STOP, dsds_pkg::TURN_STRAIGHT,
			15'd0));
		plan.push_back(item(dsds_pkg::ACT_TURN, dsds_pkg::DRV_FWD, dsds_pkg::TURN_LEFT,
			15'h7FFF));
		plan.push_back(item(dsds_pkg::ACT_TICK, dsds_pkg::DRV_STOP, dsds_pkg::TURN_STRAIGHT,
			15'd0));
		plan.push_back(wr(dsds_pkg::REG_STEP_MODE, 16'd0));
		plan.push_back(item(dsds_pkg::ACT_DIST, dsds_pkg::DRV_FWD, dsds_pkg::TURN_STRAIGHT,
			15'd500));
		plan.push_back(item(dsds_pkg::ACT_TICK, dsds_pkg::DRV_STOP, dsds_pkg::TURN_STRAIGHT,
			15'd0));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			r = plan[i];
			if (r.is_write)
				write_reg(r.reg_idx, r.reg_val);
			else
				send_item(r.act, r.ddir, r.tdir, r.amt, r.typed, r.out);
		end

		next_cfg = accepted;
		while (accepted < plan.size() + RANDOM_ITEMS) begin
			if (accepted >= next_cfg) begin
				shuffle_config();
				next_cfg = accepted + $urandom_range(50, 110);
			end
			if ($urandom_range(0, 9) < 8) begin
				// a command then a run of ticks, often long enough to finish the count
				case ($urandom_range(0, 9))
					0, 1: act = dsds_pkg::ACT_DRIVE;
					2, 3, 4, 5: act = dsds_pkg::ACT_DIST;
					default: act = dsds_pkg::ACT_TURN;
				endcase
				send_item(act, 2'($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 2)),
					2'($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 2)), rand_amount());
				n_ticks = (budget == 0) ? $urandom_range(1, 20) : budget + $urandom_range(0, 3);
				if (n_ticks > 40)
					n_ticks = $urandom_range(5, 40);
				repeat (n_ticks)
					send_item(dsds_pkg::ACT_TICK, 2'($urandom_range(0, 3)),
						2'($urandom_range(0, 3)), 15'($urandom_range(0, 32767)));
			end else begin
				repeat ($urandom_range(1, 4))
					send_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
						2'($urandom_range(0, 3)), rand_amount());
			end
		end

		if (burst_left != 0) begin
			s_tvalid <= 1'b0;
			burst_left = 0;
		end
		while (outputs_due.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && outputs_due.size() == 0) begin
			$display("dual_stepper_drive_sequencer test passed");
		end else begin
			$display("dual_stepper_drive_sequencer test failed");
		end
		$finish;
	end

endmodule
